// ----- rtl/core/blenv_pkg.sv -----
// Shared types and constants for the breakpoint linear envelope unit.
package blenv_pkg;

    localparam int MAX_SEGMENTS_DEF = 16;
    localparam int FRAME_BITS_DEF   = 20;
    localparam int LEVEL_BITS_DEF   = 16;

    localparam int CMD_BITS   = 2;
    localparam int INDEX_BITS = 4;
    localparam int CFG_IDX_BITS = 2;

    localparam logic [CMD_BITS-1:0] CMD_WRITE   = 2'd0;
    localparam logic [CMD_BITS-1:0] CMD_RESTART = 2'd1;
    localparam logic [CMD_BITS-1:0] CMD_TICK    = 2'd2;

    localparam logic [CFG_IDX_BITS-1:0] REG_INTERP_MODE     = 2'd0;
    localparam logic [CFG_IDX_BITS-1:0] REG_SEGMENT_COUNT   = 2'd1;
    localparam logic [CFG_IDX_BITS-1:0] REG_ENVELOPE_FRAMES = 2'd2;
    localparam logic [CFG_IDX_BITS-1:0] REG_START_LEVEL     = 2'd3;

    localparam int SEG_COUNT_BITS = 5;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_CHECK,
        ST_LOOK,
        ST_MUL,
        ST_DIV,
        ST_FIN,
        ST_EMIT
    } state_t;

endpackage

// ----- rtl/core/breakpoint_linear_envelope_unit.sv -----
// Piecewise-linear breakpoint envelope generator with segment table in on-chip RAM.
// A tick goes CHECK, LOOK, MUL, bit-serial DIV, FIN, EMIT when interpolating; LOOK returns to CHECK
// past zero-length segments; flat mode, or holding after the last segment, goes CHECK to EMIT. Once
// the envelope frames are all sent a tick gives no result. EMIT waits for a free output; no input is
// taken until IDLE again. Writes and restarts are taken in IDLE. The table RAM read is registered.
// Reset (rst_n, async, active low) clears control registers and counters, not data or the table RAM.
module breakpoint_linear_envelope_unit #(
    parameter int MAX_SEGMENTS = blenv_pkg::MAX_SEGMENTS_DEF,
    parameter int FRAME_BITS   = blenv_pkg::FRAME_BITS_DEF,
    parameter int LEVEL_BITS   = blenv_pkg::LEVEL_BITS_DEF,
    localparam int IN_DW  = ((blenv_pkg::INDEX_BITS + LEVEL_BITS + FRAME_BITS + 7) / 8) * 8,
    localparam int OUT_DW = ((LEVEL_BITS + FRAME_BITS + 7) / 8) * 8,
    localparam int CFG_DW = (FRAME_BITS > LEVEL_BITS) ? FRAME_BITS : LEVEL_BITS
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              s_tvalid,
    output logic                              s_tready,
    // seg_index, seg_level, seg_frames (low to high), zero padded
    input  logic [IN_DW-1:0]                  s_tdata,
    // cmd
    input  logic [blenv_pkg::CMD_BITS-1:0]    s_tuser,
    output logic                              m_tvalid,
    input  logic                              m_tready,
    // sample, frame_index (low to high), zero padded
    output logic [OUT_DW-1:0]                 m_tdata,
    // last_frame
    output logic                              m_tlast,
    input  logic                              cfg_valid,
    output logic                              cfg_ready,
    input  logic [blenv_pkg::CFG_IDX_BITS-1:0] cfg_index,
    input  logic [CFG_DW-1:0]                 cfg_data
);

    localparam int FW    = FRAME_BITS;
    localparam int LW    = LEVEL_BITS;
    localparam int MW    = LW + 1;
    localparam int PW    = FW + MW;
    localparam int AW    = (MAX_SEGMENTS > 1) ? $clog2(MAX_SEGMENTS) : 1;
    localparam int PTRW  = $clog2(MAX_SEGMENTS + 1);
    localparam int CNTW  = $clog2(MW + 1);
    localparam int IXW   = blenv_pkg::INDEX_BITS;
    localparam int SCW   = blenv_pkg::SEG_COUNT_BITS;

    // segment table: {length, target}
    logic [FW+LW-1:0] mem [MAX_SEGMENTS];
    logic [FW+LW-1:0] rd_data_reg;
    logic             wr_en;
    logic [AW-1:0]    wr_addr;

    blenv_pkg::state_t state_reg, state_next;

    logic                 mode_reg, mode_next;
    logic [SCW-1:0]       segcnt_reg, segcnt_next;
    logic [FW-1:0]        env_reg, env_next;
    logic signed [LW-1:0] start_reg, start_next;

    logic [FW-1:0]        frame_cnt_reg, frame_cnt_next;
    logic [PTRW-1:0]      ptr_reg, ptr_next;
    logic [FW-1:0]        fis_reg, fis_next;
    logic signed [LW-1:0] base_reg, base_next;

    logic                 neg_reg, neg_next;
    logic [MW-1:0]        mag_reg, mag_next;
    logic [FW-1:0]        rem_reg, rem_next;
    logic [MW-1:0]        quo_reg, quo_next;
    logic [CNTW-1:0]      cnt_reg, cnt_next;
    logic signed [LW-1:0] level_reg, level_next;

    logic                 out_valid_reg, out_valid_next;
    logic [LW-1:0]        out_sample_reg, out_sample_next;
    logic [FW-1:0]        out_index_reg, out_index_next;
    logic                 out_last_reg, out_last_next;

    logic [IXW-1:0]       in_index;
    logic signed [LW-1:0] in_level;
    logic [FW-1:0]        in_frames;
    logic                 in_xfer;

    logic signed [LW-1:0] rd_target;
    logic [FW-1:0]        rd_length;
    logic [31:0]          used;
    logic                 ptr_lt_used;
    logic signed [MW-1:0] diff;
    logic [PW-1:0]        prod;
    logic [FW:0]          trial;
    logic [FW:0]          trial_sub;
    logic                 trial_ge;
    logic signed [MW-1:0] level_sum;
    logic [FW:0]          fis_inc;
    logic [FW:0]          frame_inc;
    logic                 out_free;

    assign in_index  = s_tdata[IXW-1:0];
    assign in_level  = s_tdata[IXW +: LW];
    assign in_frames = s_tdata[IXW+LW +: FW];

    assign s_tready  = (state_reg == blenv_pkg::ST_IDLE);
    assign cfg_ready = 1'b1;
    assign in_xfer   = s_tvalid && s_tready;

    assign m_tvalid = out_valid_reg;
    assign m_tlast  = out_last_reg;
    assign m_tdata  = OUT_DW'({out_index_reg, out_sample_reg});

    assign rd_target = rd_data_reg[LW-1:0];
    assign rd_length = rd_data_reg[LW +: FW];

    assign used = (32'(segcnt_reg) > 32'(MAX_SEGMENTS)) ? 32'(MAX_SEGMENTS) : 32'(segcnt_reg);
    assign ptr_lt_used = 32'(ptr_reg) < used;

    assign diff      = MW'(rd_target) - MW'(base_reg);
    assign prod      = PW'(fis_reg) * PW'(mag_reg);
    assign trial     = {rem_reg, quo_reg[MW-1]};
    assign trial_sub = trial - {1'b0, rd_length};
    assign trial_ge  = trial >= {1'b0, rd_length};
    assign level_sum = neg_reg ? (MW'(base_reg) - $signed(quo_reg))
                               : (MW'(base_reg) + $signed(quo_reg));
    assign fis_inc   = {1'b0, fis_reg} + (FW+1)'(1);
    assign frame_inc = {1'b0, frame_cnt_reg} + (FW+1)'(1);
    assign out_free  = !out_valid_reg || m_tready;

    assign wr_en   = in_xfer && (s_tuser == blenv_pkg::CMD_WRITE) &&
                     (32'(in_index) < 32'(MAX_SEGMENTS));
    assign wr_addr = AW'(in_index);

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= {in_frames, in_level};
        end
    end

    // read the entry at the segment pointer every cycle
    always_ff @(posedge clk)
    begin
        rd_data_reg <= mem[ptr_reg[AW-1:0]];
    end

    always_comb
    begin
        state_next      = state_reg;
        mode_next       = mode_reg;
        segcnt_next     = segcnt_reg;
        env_next        = env_reg;
        start_next      = start_reg;
        frame_cnt_next  = frame_cnt_reg;
        ptr_next        = ptr_reg;
        fis_next        = fis_reg;
        base_next       = base_reg;
        neg_next        = neg_reg;
        mag_next        = mag_reg;
        rem_next        = rem_reg;
        quo_next        = quo_reg;
        cnt_next        = cnt_reg;
        level_next      = level_reg;
        out_valid_next  = out_valid_reg && !m_tready;
        out_sample_next = out_sample_reg;
        out_index_next  = out_index_reg;
        out_last_next   = out_last_reg;

        if (cfg_valid)
        begin
            case (cfg_index)
                blenv_pkg::REG_INTERP_MODE:     mode_next   = cfg_data[0];
                blenv_pkg::REG_SEGMENT_COUNT:   segcnt_next = cfg_data[SCW-1:0];
                blenv_pkg::REG_ENVELOPE_FRAMES: env_next    = cfg_data[FW-1:0];
                blenv_pkg::REG_START_LEVEL:
                begin
                    start_next = cfg_data[LW-1:0];
                    if (frame_cnt_reg == '0)
                    begin
                        base_next = cfg_data[LW-1:0];
                    end
                end
                default: ;
            endcase
        end

        case (state_reg)
            blenv_pkg::ST_IDLE:
            begin
                if (in_xfer)
                begin
                    case (s_tuser)
                        blenv_pkg::CMD_RESTART:
                        begin
                            frame_cnt_next = '0;
                            ptr_next       = '0;
                            fis_next       = '0;
                            base_next      = start_reg;
                        end
                        blenv_pkg::CMD_TICK: state_next = blenv_pkg::ST_CHECK;
                        default: ;
                    endcase
                end
            end
            blenv_pkg::ST_CHECK:
            begin
                if (frame_cnt_reg >= env_reg)
                begin
                    state_next = blenv_pkg::ST_IDLE;
                end
                else if (mode_reg)
                begin
                    level_next = start_reg;
                    state_next = blenv_pkg::ST_EMIT;
                end
                else if (ptr_lt_used)
                begin
                    state_next = blenv_pkg::ST_LOOK;
                end
                else
                begin
                    level_next = base_reg;
                    state_next = blenv_pkg::ST_EMIT;
                end
            end
            blenv_pkg::ST_LOOK:
            begin
                if (rd_length == '0)
                begin
                    // jump segment: take its target, no frame used
                    base_next  = rd_target;
                    ptr_next   = ptr_reg + PTRW'(1);
                    fis_next   = '0;
                    state_next = blenv_pkg::ST_CHECK;
                end
                else
                begin
                    neg_next   = diff < 0;
                    mag_next   = (diff < 0) ? MW'(-diff) : MW'(diff);
                    state_next = blenv_pkg::ST_MUL;
                end
            end
            blenv_pkg::ST_MUL:
            begin
                // quotient < mag fits MW bits, so the upper part is already below len
                rem_next   = prod[PW-1:MW];
                quo_next   = prod[MW-1:0];
                cnt_next   = CNTW'(MW);
                state_next = blenv_pkg::ST_DIV;
            end
            blenv_pkg::ST_DIV:
            begin
                rem_next = trial_ge ? trial_sub[FW-1:0] : trial[FW-1:0];
                quo_next = {quo_reg[MW-2:0], trial_ge};
                cnt_next = cnt_reg - CNTW'(1);
                if (cnt_reg == CNTW'(1))
                begin
                    state_next = blenv_pkg::ST_FIN;
                end
            end
            blenv_pkg::ST_FIN:
            begin
                level_next = level_sum[LW-1:0];
                if (fis_inc >= {1'b0, rd_length})
                begin
                    base_next = rd_target;
                    ptr_next  = ptr_reg + PTRW'(1);
                    fis_next  = '0;
                end
                else
                begin
                    fis_next = fis_inc[FW-1:0];
                end
                state_next = blenv_pkg::ST_EMIT;
            end
            blenv_pkg::ST_EMIT:
            begin
                if (out_free)
                begin
                    out_valid_next  = 1'b1;
                    out_sample_next = level_reg;
                    out_index_next  = frame_cnt_reg;
                    out_last_next   = (frame_inc == {1'b0, env_reg});
                    frame_cnt_next  = frame_inc[FW-1:0];
                    state_next      = blenv_pkg::ST_IDLE;
                end
            end
            default: state_next = blenv_pkg::ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= blenv_pkg::ST_IDLE;
            mode_reg      <= 1'b0;
            segcnt_reg    <= '0;
            env_reg       <= '0;
            start_reg     <= '0;
            frame_cnt_reg <= '0;
            ptr_reg       <= '0;
            fis_reg       <= '0;
            base_reg      <= '0;
            cnt_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            mode_reg      <= mode_next;
            segcnt_reg    <= segcnt_next;
            env_reg       <= env_next;
            start_reg     <= start_next;
            frame_cnt_reg <= frame_cnt_next;
            ptr_reg       <= ptr_next;
            fis_reg       <= fis_next;
            base_reg      <= base_next;
            cnt_reg       <= cnt_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        neg_reg        <= neg_next;
        mag_reg        <= mag_next;
        rem_reg        <= rem_next;
        quo_reg        <= quo_next;
        level_reg      <= level_next;
        out_sample_reg <= out_sample_next;
        out_index_reg  <= out_index_next;
        out_last_reg   <= out_last_next;
    end

endmodule

// ----- rtl/core/blenv_checker.sv -----
// Port-level assertions for the breakpoint linear envelope unit, with bind.
module blenv_checker #(
    parameter int IN_DW  = 40,
    parameter int OUT_DW = 40
) (
    input logic                           clk,
    input logic                           rst_n,
    input logic                           s_tvalid,
    input logic                           s_tready,
    input logic [IN_DW-1:0]               s_tdata,
    input logic [blenv_pkg::CMD_BITS-1:0] s_tuser,
    input logic                           m_tvalid,
    input logic                           m_tready,
    input logic [OUT_DW-1:0]              m_tdata,
    input logic                           m_tlast
);

    logic in_xfer;

    assign in_xfer = s_tvalid && s_tready && (s_tdata == s_tdata);

    // stalled result holds
    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast))
        else $error("result changed or dropped while stalled");

    // no input transfer produces a result in the very next cycle
    assert property (@(posedge clk) disable iff (!rst_n)
        in_xfer |=> !$rose(m_tvalid))
        else $error("result appeared one cycle after an input transfer");

    // a tick holds off further input while it is worked on
    assert property (@(posedge clk) disable iff (!rst_n)
        in_xfer && (s_tuser == blenv_pkg::CMD_TICK) |=> !s_tready)
        else $error("input accepted right after a tick transfer");

endmodule

bind breakpoint_linear_envelope_unit blenv_checker #(
    .IN_DW  (IN_DW),
    .OUT_DW (OUT_DW)
) u_blenv_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast)
);
